// File: rtl/core/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types, constants and sigmoid table generation for the SiLU-gated
// multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

	localparam int DATA_W = 16;               // Q-format element width
	localparam int SIG_W = 17;                // sigmoid in unsigned Q0.16, 1.0 included
	localparam logic [SIG_W-1:0] SIG_ONE = 17'd65536;
	localparam int SGM_LATENCY = 8;           // start to done, in cycles

	localparam longint unsigned Q30_ONE = 64'd1 << 30;

	typedef struct packed {
		logic signed [DATA_W-1:0] gate_value;
		logic signed [DATA_W-1:0] up_value;
	} sgm_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product;
		logic                     saturated;
	} sgm_out_t;

	// Shift-subtract divide, elaboration use only.
	function automatic longint unsigned sgm_udiv(input longint unsigned n,
		input longint unsigned d);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= d) begin
				rem = rem - d;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Table entry i: sigmoid(-8 + 16*i/depth) in Q0.16, round to nearest.
	// e^-|x| from a truncated Taylor series of e^-(|x|/256), squared 8 times.
	function automatic logic [SIG_W-1:0] sig_entry(input int unsigned i,
		input int unsigned depth);
		longint signed num;
		logic neg;
		longint unsigned an, z, t1, t2, t3, t4, e, den, v;
		if (i >= depth) begin
			return SIG_ONE;
		end
		num = 64'(16 * longint'(i)) - 64'(8 * longint'(depth));
		neg = (num < 0);
		an = neg ? 64'(-num) : 64'(num);
		z = sgm_udiv(an << 30, 64'(depth) * 64'd256);
		t1 = (Q30_ONE * z) >> 30;
		t2 = ((t1 * z) >> 30) >> 1;
		t3 = ((t2 * z) >> 30) / 3;
		t4 = ((t3 * z) >> 30) >> 2;
		e = Q30_ONE - t1 + t2 - t3 + t4;
		for (int k = 0; k < 8; k++) begin
			e = (e * e) >> 30;
		end
		den = Q30_ONE + e;
		if (neg) begin
			v = sgm_udiv((e << 16) + (den >> 1), den);
		end else begin
			v = sgm_udiv((64'd1 << 46) + (den >> 1), den);
		end
		return v[SIG_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/silu_gated_multiply.sv
// ----------------------------------------------------------------------------
// silu_gated_multiply
// Element-wise SwiGLU core: product = gate * sigmoid(gate) * up, Q-format.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive operand (gate_value, up_value) and raise start; the
//   transaction is taken on any rising edge where start is high and busy is
//   low. busy is held low: the pipeline takes one transaction every cycle.
//   Output channel: done pulses for one cycle with result (product,
//   saturated). The receiver has no stall, so each result must be taken in
//   the cycle it appears.
//   Throughput is one transaction per cycle. The pipeline is four sigmoid
//   stages (index split, table read, slope multiply, interpolate), then
//   gate*sigmoid, rounding, times up, and the round/saturate output
//   register.
//   Reset clears every valid bit, so nothing is in flight afterwards; the
//   sigmoid table is constant logic and needs no fill.
//   Results come out in the order transactions went in.
// ----------------------------------------------------------------------------
`default_nettype none

module silu_gated_multiply #(
	parameter int FRAC_BITS           = 12,
	parameter int SIGMOID_TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sgm_pkg::sgm_in_t   operand,
	output logic               done,
	output sgm_pkg::sgm_out_t  result
);
	import sgm_pkg::*;

	localparam int GSW = DATA_W + SIG_W + 1;   // gate * sigmoid
	localparam int SLW = DATA_W + 2;           // rounded silu
	localparam int PRW = SLW + DATA_W;         // silu * up
	localparam int RNW = PRW + 1;
	localparam int SHW = RNW - FRAC_BITS;
	localparam logic signed [SHW-1:0] MAX_V = SHW'({1'b0, {(DATA_W-1){1'b1}}});
	localparam logic signed [SHW-1:0] MIN_V = SHW'($signed({1'b1, {(DATA_W-1){1'b0}}}));
	localparam logic signed [GSW-1:0] HALF_LSB16 = GSW'(32768);
	localparam logic signed [RNW-1:0] HALF_LSBF  = RNW'(64'sd1 << (FRAC_BITS - 1));

	logic take;
	assign busy = 1'b0;              // fully pipelined, never refuses
	assign take = start && !busy;

	// sigmoid(gate) from the sgm_sigmoid pipeline
	logic             sig_valid;
	logic [SIG_W-1:0] sig_val;

	sgm_sigmoid #(
		.FRAC_BITS (FRAC_BITS),
		.DEPTH     (SIGMOID_TABLE_DEPTH)
	) u_sigmoid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (take),
		.gate      (operand.gate_value),
		.out_valid (sig_valid),
		.sig       (sig_val)
	);

	// operands ride alongside the sigmoid stages
	sgm_in_t op_s1, op_s2, op_s3, op_s4;

	always_ff @(posedge clk) begin
		op_s1 <= operand;
		op_s2 <= op_s1;
		op_s3 <= op_s2;
		op_s4 <= op_s3;
	end

	// stage 5: gate * sigmoid
	logic                      valid_s5;
	logic signed [GSW-1:0]     gs_s5;
	logic signed [DATA_W-1:0]  up_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= sig_valid;
		end
	end

	always_ff @(posedge clk) begin
		gs_s5 <= GSW'(op_s4.gate_value) * $signed({{(GSW-SIG_W){1'b0}}, sig_val});
		up_s5 <= op_s4.up_value;
	end

	// stage 6: round to Q.FRAC (floor of +half)
	logic signed [GSW-1:0] gs_rnd;
	assign gs_rnd = gs_s5 + HALF_LSB16;

	logic                     valid_s6;
	logic signed [SLW-1:0]    silu_s6;
	logic signed [DATA_W-1:0] up_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		silu_s6 <= gs_rnd[16 +: SLW];
		up_s6   <= up_s5;
	end

	// stage 7: silu * up
	logic                  valid_s7;
	logic signed [PRW-1:0] pr_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		pr_s7 <= PRW'(silu_s6) * PRW'(up_s6);
	end

	// stage 8: round half up, saturate, output register
	logic signed [RNW-1:0] pr_rnd;
	logic signed [SHW-1:0] pr_sh;
	assign pr_rnd = RNW'(pr_s7) + HALF_LSBF;
	assign pr_sh  = pr_rnd[RNW-1:FRAC_BITS];

	logic     done_q;
	sgm_out_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (pr_sh > MAX_V) begin
			result_q.product   <= MAX_V[DATA_W-1:0];
			result_q.saturated <= 1'b1;
		end else if (pr_sh < MIN_V) begin
			result_q.product   <= MIN_V[DATA_W-1:0];
			result_q.saturated <= 1'b1;
		end else begin
			result_q.product   <= pr_sh[DATA_W-1:0];
			result_q.saturated <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: rtl/core/sgm_sigmoid.sv
// ----------------------------------------------------------------------------
// sgm_sigmoid
// Four-stage sigmoid: index/fraction split, table read, slope multiply,
// interpolate with clamping outside [-8, 8).
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_sigmoid #(
	parameter int FRAC_BITS = 12,
	parameter int DEPTH     = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [sgm_pkg::DATA_W-1:0]   gate,
	output logic                                out_valid,
	output logic        [sgm_pkg::SIG_W-1:0]    sig
);
	import sgm_pkg::*;

	localparam int GW  = ((DATA_W > FRAC_BITS + 4) ? DATA_W : FRAC_BITS + 4) + 1;
	localparam int PW  = FRAC_BITS + 4;       // bits of one 16-wide span
	localparam int DBW = $clog2(DEPTH + 1);
	localparam int QW  = PW + DBW;
	localparam int IW  = $clog2(DEPTH);
	localparam int RW  = $clog2(DEPTH + 1);
	localparam int DW  = SIG_W + 1;           // signed slope
	localparam int TW  = DW + PW + 1;
	localparam logic signed [GW-1:0] HALF = GW'(64'sd8 << FRAC_BITS);

	logic [SIG_W-1:0] sig_rom [DEPTH+1];

	for (genvar i = 0; i <= DEPTH; i++) begin : g_rom
		assign sig_rom[i] = sig_entry(i, DEPTH);
	end

	logic signed [GW-1:0] g_ext;
	logic signed [GW-1:0] p_full;
	logic        [QW-1:0] q;

	assign g_ext  = GW'(gate);
	assign p_full = g_ext + HALF;
	assign q      = QW'(p_full[PW-1:0]) * QW'(DEPTH);

	// stage 1: split position into table index and fraction
	logic          valid_s1, lo_s1, hi_s1;
	logic [IW-1:0] idx_s1;
	logic [PW-1:0] r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= q[PW +: IW];
		r_s1   <= q[PW-1:0];
		lo_s1  <= (g_ext < -HALF);
		hi_s1  <= (g_ext >= HALF);
	end

	// stage 2: neighboring table entries
	logic             valid_s2, lo_s2, hi_s2;
	logic [SIG_W-1:0] s0_s2, s1_s2;
	logic [PW-1:0]    r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		s0_s2 <= sig_rom[RW'(idx_s1)];
		s1_s2 <= sig_rom[RW'(idx_s1) + RW'(1)];
		r_s2  <= r_s1;
		lo_s2 <= lo_s1;
		hi_s2 <= hi_s1;
	end

	// stage 3: slope times fraction
	logic signed [DW-1:0] slope;
	assign slope = $signed({1'b0, s1_s2}) - $signed({1'b0, s0_s2});

	logic                    valid_s3, lo_s3, hi_s3;
	logic        [SIG_W-1:0] s0_s3;
	logic signed [TW-1:0]    t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		t_s3  <= TW'(slope) * TW'($signed({1'b0, r_s2}));
		s0_s3 <= s0_s2;
		lo_s3 <= lo_s2;
		hi_s3 <= hi_s2;
	end

	// stage 4: floor of the fractional step, then clamp
	logic signed [TW-1:0]      f_full;
	logic signed [SIG_W+1:0]   s_sum;
	assign f_full = t_s3 >>> PW;
	assign s_sum  = $signed({2'b00, s0_s3}) + (SIG_W+2)'(f_full);

	logic             valid_s4;
	logic [SIG_W-1:0] sig_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (lo_s3) begin
			sig_s4 <= '0;
		end else if (hi_s3) begin
			sig_s4 <= SIG_ONE;
		end else begin
			sig_s4 <= s_sum[SIG_W-1:0];
		end
	end

	assign out_valid = valid_s4;
	assign sig       = sig_s4;

endmodule

`default_nettype wire

// File: rtl/core/sgm_check.sv
// ----------------------------------------------------------------------------
// sgm_check
// Port-level checks on the SiLU-gated multiply, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_check (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input sgm_pkg::sgm_out_t result
);
	import sgm_pkg::*;

	localparam logic signed [DATA_W-1:0] P_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] P_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// every accepted transaction yields one result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##SGM_LATENCY done)
		else $error("sgm: accepted transaction produced no result");

	// no result without a matching transaction
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, SGM_LATENCY))
		else $error("sgm: result without a transaction");

	// a saturated result sits at one of the limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
			(result.product == P_MAX || result.product == P_MIN))
		else $error("sgm: saturated flag with in-range product");

	// the pipeline never back-pressures
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("sgm: busy raised");

endmodule

bind silu_gated_multiply sgm_check u_sgm_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

// File: verif/tb_silu_gated_multiply.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_silu_gated_multiply
// Self-checking bench for the SiLU-gated multiply core. Operand pairs go in
// through start/busy, in bursts with random gaps between them. Each accepted
// transaction is run through a bit-exact fixed-point model: an interpolated
// sigmoid table, gate*sigmoid, times up, then round and saturate. Every done
// pulse is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_silu_gated_multiply;

	import sgm_pkg::*;

	localparam int FRAC          = 12;
	localparam int TABLE_DEPTH   = 256;
	localparam int NUM_RANDOM    = 1700;
	localparam int CLK_PERIOD    = 8;
	localparam int CYCLE_LIMIT   = 400000;

	// ------------------------------------------------------------------------
	// Scoreboard: fixed-point model of the core plus the in-order queue of
	// results that have not come out yet.
	// ------------------------------------------------------------------------
	class swiglu_scoreboard;
		logic [SIG_W-1:0] sigmoid_q16[TABLE_DEPTH];
		sgm_out_t         pending_products[$];
		int               failures;

		function new();
			longint signed   x_num;
			longint unsigned mag, z, term1, term2, term3, term4, e_val, den;
			failures = 0;
			// Entry i holds sigmoid(-8 + 16*i/DEPTH) in Q0.16. e^-|x| comes
			// from a truncated Taylor series of e^-(|x|/256), squared 8 times.
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				x_num = 16 * longint'(i) - 8 * longint'(TABLE_DEPTH);
				mag   = (x_num < 0) ? longint'(-x_num) : longint'(x_num);
				z     = (mag << 30) / (longint'(TABLE_DEPTH) * 256);
				term1 = (Q30_ONE * z) >> 30;
				term2 = ((term1 * z) >> 30) / 2;
				term3 = ((term2 * z) >> 30) / 3;
				term4 = ((term3 * z) >> 30) / 4;
				e_val = Q30_ONE - term1 + term2 - term3 + term4;
				for (int k = 0; k < 8; k++) begin
					e_val = (e_val * e_val) >> 30;
				end
				den = Q30_ONE + e_val;
				if (x_num < 0) begin
					sigmoid_q16[i] = SIG_W'(((e_val << 16) + (den >> 1)) / den);
				end else begin
					sigmoid_q16[i] = SIG_W'(((64'd1 << 46) + (den >> 1)) / den);
				end
			end
		endfunction

		// gate * sigmoid(gate) * up with the core's rounding and clamping
		function sgm_out_t swiglu_product(input sgm_in_t op);
			longint signed g, u, half_range, pos, q, r, s0, s1, sig, silu, prod;
			longint signed max_v, min_v;
			longint unsigned idx;
			sgm_out_t res;
			g          = op.gate_value;
			u          = op.up_value;
			half_range = longint'(8) << FRAC;
			max_v      = (longint'(1) << (DATA_W - 1)) - 1;
			min_v      = -max_v - 1;
			if (g < -half_range) begin
				sig = 0;
			end else if (g >= half_range) begin
				sig = SIG_ONE;
			end else begin
				pos = g + half_range;
				q   = pos * TABLE_DEPTH;
				idx = q >> (FRAC + 4);
				r   = q & ((longint'(1) << (FRAC + 4)) - 1);
				s0  = sigmoid_q16[idx];
				s1  = (idx + 1 < TABLE_DEPTH) ? longint'(sigmoid_q16[idx + 1]) : SIG_ONE;
				sig = s0 + (((s1 - s0) * r) >>> (FRAC + 4));
			end
			silu = (g * sig + 32768) >>> 16;
			prod = (silu * u + (longint'(1) << (FRAC - 1))) >>> FRAC;
			res.saturated = 1'b0;
			if (prod > max_v) begin
				prod = max_v;
				res.saturated = 1'b1;
			end else if (prod < min_v) begin
				prod = min_v;
				res.saturated = 1'b1;
			end
			res.product = DATA_W'(prod);
			return res;
		endfunction

		function void note_operand(input sgm_in_t op);
			pending_products.push_back(swiglu_product(op));
		endfunction

		function void check_result(input sgm_out_t got);
			sgm_out_t want;
			if (pending_products.size() == 0) begin
				$error("result with no transaction outstanding: product %0d saturated %0b",
					got.product, got.saturated);
				failures++;
				return;
			end
			want = pending_products.pop_front();
			if (got.product !== want.product) begin
				$error("product: expected %0d, got %0d", want.product, got.product);
				failures++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
				failures++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT and clock/reset
	// ------------------------------------------------------------------------
	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	sgm_in_t  operand;
	logic     done;
	sgm_out_t result;

	swiglu_scoreboard sb;
	int unsigned      cycle_count;

	silu_gated_multiply #(
		.FRAC_BITS          (FRAC),
		.SIGMOID_TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.operand(operand),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Watchdog: a correct run takes a small fraction of this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Monitors. Inputs move on the falling edge, so the values read here at
	// the rising edge are the ones the DUT sees at this edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(result);
		end
		if (arst_n && start && !busy) begin
			sb.note_operand(operand);
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks
	// ------------------------------------------------------------------------

	// Present one transaction and hold it until the accepting edge. start is
	// left high, so back-to-back calls stream without a bubble.
	task automatic send_operand(input logic signed [DATA_W-1:0] gate,
		input logic signed [DATA_W-1:0] up);
		@(negedge clk);
		start              <= 1'b1;
		operand.gate_value <= gate;
		operand.up_value   <= up;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for some cycles; the operand bus carries junk meanwhile.
	task automatic idle_cycles(input int n);
		for (int i = 0; i < n; i++) begin
			@(negedge clk);
			start   <= 1'b0;
			operand <= sgm_in_t'($urandom);
		end
	endtask

	// Random operand pair, weighted toward the interesting regions
	task automatic send_random();
		logic signed [DATA_W-1:0] gate, up;
		int mode;
		mode = $urandom_range(0, 9);
		gate = DATA_W'($urandom);
		up   = DATA_W'($urandom);
		case (mode)
			5, 6: begin
				// around zero, where sigmoid bends most
				gate = DATA_W'(int'($urandom_range(0, 16383)) - 8192);
				up   = DATA_W'(int'($urandom_range(0, 16383)) - 8192);
			end
			7: begin
				// large positive gate, large up: drives the clamp
				gate = DATA_W'($urandom_range(16384, 32767));
				up   = $urandom_range(0, 1) ? DATA_W'($urandom_range(16384, 32767))
				                            : DATA_W'(-int'($urandom_range(16384, 32768)));
			end
			8: begin
				// very negative gate: sigmoid near zero
				gate = DATA_W'(-int'($urandom_range(24576, 32768)));
			end
			9: begin
				// on a table knot, or one step off it
				gate = DATA_W'(int'($urandom_range(0, 255)) * 256 - 32768
					+ int'($urandom_range(0, 2)) - 1);
			end
			default: ;
		endcase
		send_operand(gate, up);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int sent;
		int burst_len;
		int gap_len;
		sb          = new();
		arst_n      = 1'b0;
		start       = 1'b0;
		operand     = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, zero, unity, table ends and knots, clamps.
		send_operand(16'sd0, 16'sd0);
		send_operand(-16'sd32768, 16'sd32767);      // sigmoid from entry 0
		send_operand(-16'sd32768, -16'sd32768);
		send_operand(16'sd32767, 16'sd32767);       // clamps high
		send_operand(16'sd32767, -16'sd32768);      // clamps low
		send_operand(16'sd32767, 16'sd4096);        // just under the clamp
		send_operand(16'sd4096, 16'sd4096);         // silu(1.0) * 1.0
		send_operand(-16'sd4096, 16'sd4096);
		send_operand(16'sd0, 16'sd32767);
		send_operand(16'sd32767, 16'sd0);
		send_operand(16'sd1, 16'sd1);
		send_operand(-16'sd1, -16'sd1);
		send_operand(-16'sd32513, 16'sd32767);      // last step before entry 1
		send_operand(16'sd32512, 16'sd12345);       // last entry, slope to 1.0
		send_operand(16'sd32767, 16'sd1);
		send_operand(16'sd256, -16'sd7000);         // table knot just past zero
		send_operand(-16'sd256, 16'sd7000);
		send_operand(16'sd8192, -16'sd32768);
		send_operand(-16'sd20000, 16'sd32767);
		send_operand(16'sd2048, -16'sd2048);        // rounding half cases
		idle_cycles(3);

		// Random: bursts with gaps, some long stretches with no gap at all.
		sent = 0;
		while (sent < NUM_RANDOM) begin
			burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
			                                        : $urandom_range(1, 40);
			for (int i = 0; i < burst_len && sent < NUM_RANDOM; i++) begin
				send_random();
				sent++;
			end
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			idle_cycles(gap_len);
		end
		idle_cycles(1);

		// Drain, then keep the clock running to catch stray results.
		while (sb.pending_products.size() != 0) @(posedge clk);
		repeat (2 * SGM_LATENCY) @(posedge clk);

		if (sb.failures == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
